FILE: hw/rtl/wvnn_pkg.sv
// Shared types and constants of the weight vector nearest neighbour block.
// Request, result, store, scan-control and sort-cell types; no dependencies.
package wvnn_pkg;

	localparam int MAX_VECTORS    = 256;
	localparam int MAX_OBJECTIVES = 4;
	localparam int MAX_NEIGHBOURS = 32;
	localparam int COORD_BITS     = 16;

	localparam int VEC_BITS      = 8;
	localparam int OBJ_BITS      = 2;
	localparam int COORD_IN_BITS = 16;
	localparam int RANK_BITS     = 5;
	localparam int VC_BITS       = 9;
	localparam int OC_BITS       = 3;
	localparam int NC_BITS       = 6;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 9;

	localparam int DIST_BITS = 2 * COORD_BITS + 1;
	localparam int PROD_BITS = 2 * COORD_BITS;
	localparam int SUM_BITS  = PROD_BITS + $clog2(MAX_OBJECTIVES) + 1;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [CFG_IDX_BITS-1:0] CFG_VECTOR_COUNT    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_OBJECTIVE_COUNT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_NEIGHBOUR_COUNT = 2'd2;

	typedef struct packed {
		logic                     kind;
		logic [VEC_BITS-1:0]      vector_index;
		logic [OBJ_BITS-1:0]      objective_index;
		logic [COORD_IN_BITS-1:0] coordinate;
	} request_t;

	typedef struct packed {
		logic [VEC_BITS-1:0]  neighbour_index;
		logic [RANK_BITS-1:0] rank;
		logic                 last;
	} result_t;

	typedef struct packed {
		logic                  en;
		logic [VEC_BITS-1:0]   vec;
		logic [OBJ_BITS-1:0]   obj;
		logic [COORD_BITS-1:0] coord;
	} store_wr_t;

	typedef struct packed {
		logic                issue;
		logic                scan;
		logic                skip;
		logic                capture;
		logic [VEC_BITS-1:0] addr;
		logic [OC_BITS-1:0]  objs;
	} scan_ctl_t;

	typedef struct packed {
		logic                 valid;
		logic [DIST_BITS-1:0] dist_sq;
		logic [VEC_BITS-1:0]  idx;
	} entry_t;

	typedef struct packed {
		logic                 clear;
		logic                 insert;
		logic                 shift;
		logic [DIST_BITS-1:0] dist_sq;
		logic [VEC_BITS-1:0]  idx;
	} cell_ctl_t;

endpackage

FILE: hw/rtl/wvnn_dist.sv
// Weight store, one memory lane per coordinate, and the distance pipeline.
// Streams one candidate vector per cycle into a saturated squared distance.
// Depends on wvnn_pkg.
module wvnn_dist (
	input  logic                clk,
	input  logic                arst_n,
	input  wvnn_pkg::store_wr_t wr,
	input  wvnn_pkg::scan_ctl_t ctl,
	output wvnn_pkg::entry_t    cand
);
	import wvnn_pkg::*;

	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

	logic [COORD_BITS-1:0] rd_s1 [MAX_OBJECTIVES];
	logic [COORD_BITS-1:0] query_q [MAX_OBJECTIVES];
	logic [PROD_BITS-1:0]  prod_s2 [MAX_OBJECTIVES];
	logic [VEC_BITS-1:0]   idx_s1, idx_s2, idx_s3;
	logic                  valid_s1, valid_s2, valid_s3;
	logic [DIST_BITS-1:0]  dist_s3;
	logic [SUM_BITS-1:0]   sum;

	for (genvar lane = 0; lane < MAX_OBJECTIVES; lane++) begin : g_lane
		logic [COORD_BITS-1:0] mem [MAX_VECTORS];
		logic [COORD_BITS-1:0] diff;

		always_ff @(posedge clk) begin
			if (wr.en && wr.obj == OBJ_BITS'(lane)) begin
				mem[wr.vec] <= wr.coord;
			end
			if (ctl.issue) begin
				rd_s1[lane] <= mem[ctl.addr];
			end
			if (ctl.capture) begin
				query_q[lane] <= rd_s1[lane];
			end
		end

		always_comb begin
			diff = (rd_s1[lane] > query_q[lane]) ? rd_s1[lane] - query_q[lane]
				: query_q[lane] - rd_s1[lane];
		end

		always_ff @(posedge clk) begin
			if (OC_BITS'(lane) < ctl.objs) begin
				prod_s2[lane] <= PROD_BITS'(diff) * PROD_BITS'(diff);
			end else begin
				prod_s2[lane] <= '0;
			end
		end
	end

	always_comb begin
		sum = '0;
		for (int k = 0; k < MAX_OBJECTIVES; k++) begin
			sum = sum + SUM_BITS'(prod_s2[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= ctl.issue && ctl.scan && !ctl.skip;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= ctl.addr;
		idx_s2  <= idx_s1;
		idx_s3  <= idx_s2;
		dist_s3 <= (sum > SUM_BITS'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];
	end

	assign cand.valid   = valid_s3;
	assign cand.dist_sq = dist_s3;
	assign cand.idx     = idx_s3;

endmodule

FILE: hw/rtl/wvnn_cell.sv
// One place of the sorted neighbour list: holds a distance and an index.
// Inserts in order beside its neighbours and shifts toward the head on output.
// Depends on wvnn_pkg.
module wvnn_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  wvnn_pkg::cell_ctl_t ctl,
	input  wvnn_pkg::entry_t    up,
	input  logic                up_keep,
	input  wvnn_pkg::entry_t    down,
	output wvnn_pkg::entry_t    ent,
	output logic                keep
);
	import wvnn_pkg::*;

	entry_t ent_q;

	assign keep = ent_q.valid && (ent_q.dist_sq <= ctl.dist_sq);
	assign ent  = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q.valid <= 1'b0;
		end else if (ctl.clear) begin
			ent_q.valid <= 1'b0;
		end else if (ctl.shift) begin
			ent_q <= down;
		end else if (ctl.insert && !keep) begin
			if (up_keep) begin
				ent_q.valid   <= 1'b1;
				ent_q.dist_sq <= ctl.dist_sq;
				ent_q.idx     <= ctl.idx;
			end else begin
				ent_q <= up;
			end
		end
	end

endmodule

FILE: hw/rtl/weight_vector_nearest_neighbours.sv
// Top level: configuration registers, query sequencer and the chain of sort cells.
// Depends on wvnn_pkg, wvnn_dist and wvnn_cell.
//
//  channel  | signals                      | taken when
//  ---------+------------------------------+------------------------------
//  request  | start, busy, request         | start high and busy low
//  result   | result_valid, result         | every cycle result_valid is high
//  config   | cfg_write, cfg_index, cfg_data | every cycle cfg_write is high
//
// A load leaves busy low. A query scans the weight store one stored
// vector per cycle, then reports its n neighbours as results that follow
// back to back. Reset clears the registers to their defaults and the
// cell list; the store holds nothing defined until written. Results cannot stall.
module weight_vector_nearest_neighbours (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  wvnn_pkg::request_t                    request,
	output logic                                  result_valid,
	output wvnn_pkg::result_t                     result,
	input  logic                                  cfg_write,
	input  logic [wvnn_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [wvnn_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import wvnn_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_QREAD = 6'b000010,
		ST_QCAP  = 6'b000100,
		ST_SCAN  = 6'b001000,
		ST_DRAIN = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	localparam entry_t EMPTY = '0;

	state_t              state_q;
	logic [VC_BITS-1:0]  vector_count_q;
	logic [OC_BITS-1:0]  objective_count_q;
	logic [NC_BITS-1:0]  neighbour_count_q;
	logic [VC_BITS-1:0]  vc, vc_q;
	logic [VC_BITS-1:0]  want;
	logic [OC_BITS-1:0]  objs, objs_q;
	logic [NC_BITS-1:0]  want_q;
	logic [VEC_BITS-1:0] vec_q;
	logic [VEC_BITS-1:0] j_q;
	logic [1:0]          drain_q;
	logic [RANK_BITS-1:0] emit_q;
	logic                accept;
	logic                emit_last;

	store_wr_t wr;
	scan_ctl_t sctl;
	entry_t    cand;
	cell_ctl_t cctl;
	entry_t    ent [MAX_NEIGHBOURS];
	logic      keep [MAX_NEIGHBOURS];

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_count_q    <= VC_BITS'(256);
			objective_count_q <= OC_BITS'(3);
			neighbour_count_q <= NC_BITS'(10);
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_VECTOR_COUNT:    vector_count_q    <= cfg_data;
				CFG_OBJECTIVE_COUNT: objective_count_q <= cfg_data[OC_BITS-1:0];
				CFG_NEIGHBOUR_COUNT: neighbour_count_q <= cfg_data[NC_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		vc = (vector_count_q > VC_BITS'(MAX_VECTORS)) ? VC_BITS'(MAX_VECTORS) : vector_count_q;
		objs = (objective_count_q > OC_BITS'(MAX_OBJECTIVES)) ? OC_BITS'(MAX_OBJECTIVES)
			: objective_count_q;
		want = VC_BITS'(neighbour_count_q);
		if (vc < VC_BITS'(2)) begin
			want = '0;
		end else begin
			if (want > vc - VC_BITS'(1)) want = vc - VC_BITS'(1);
			if (want > VC_BITS'(MAX_NEIGHBOURS)) want = VC_BITS'(MAX_NEIGHBOURS);
		end
	end

	assign emit_last = ({1'b0, emit_q} == want_q - NC_BITS'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			j_q     <= '0;
			drain_q <= '0;
			emit_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && request.kind == KIND_QUERY && want != '0) begin
						state_q <= ST_QREAD;
					end
				end
				ST_QREAD: state_q <= ST_QCAP;
				ST_QCAP: begin
					j_q     <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					j_q <= j_q + VEC_BITS'(1);
					if ({1'b0, j_q} == vc_q - VC_BITS'(1)) begin
						drain_q <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 2'd1;
					if (drain_q == 2'd2) begin
						emit_q  <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					emit_q <= emit_q + RANK_BITS'(1);
					if (emit_last) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && request.kind == KIND_QUERY) begin
			vec_q  <= request.vector_index;
			vc_q   <= vc;
			objs_q <= objs;
			want_q <= want[NC_BITS-1:0];
		end
	end

	always_comb begin
		wr.en    = accept && request.kind == KIND_LOAD;
		wr.vec   = request.vector_index;
		wr.obj   = request.objective_index;
		wr.coord = COORD_BITS'(request.coordinate);

		sctl.issue   = (state_q == ST_QREAD) || (state_q == ST_SCAN);
		sctl.scan    = (state_q == ST_SCAN);
		sctl.skip    = (j_q == vec_q);
		sctl.capture = (state_q == ST_QCAP);
		sctl.addr    = (state_q == ST_SCAN) ? j_q : vec_q;
		sctl.objs    = objs_q;

		cctl.clear   = (state_q == ST_QREAD);
		cctl.insert  = cand.valid;
		cctl.shift   = (state_q == ST_EMIT);
		cctl.dist_sq = cand.dist_sq;
		cctl.idx     = cand.idx;
	end

	wvnn_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.ctl    (sctl),
		.cand   (cand)
	);

	for (genvar i = 0; i < MAX_NEIGHBOURS; i++) begin : g_cell
		entry_t up_ent;
		entry_t down_ent;
		logic   up_keep;

		if (i == 0) begin : g_head
			assign up_ent  = EMPTY;
			assign up_keep = 1'b1;
		end else begin : g_body
			assign up_ent  = ent[i-1];
			assign up_keep = keep[i-1];
		end

		if (i == MAX_NEIGHBOURS - 1) begin : g_tail
			assign down_ent = EMPTY;
		end else begin : g_inner
			assign down_ent = ent[i+1];
		end

		wvnn_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cctl),
			.up      (up_ent),
			.up_keep (up_keep),
			.down    (down_ent),
			.ent     (ent[i]),
			.keep    (keep[i])
		);
	end

	assign result_valid           = (state_q == ST_EMIT);
	assign result.neighbour_index = ent[0].idx;
	assign result.rank            = emit_q;
	assign result.last            = emit_last;

endmodule

FILE: hw/rtl/wvnn_checker.sv
// Port-level checks on the request and result channels of the top level.
// Depends on wvnn_pkg; bound to weight_vector_nearest_neighbours below.
module wvnn_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input wvnn_pkg::request_t request,
	input logic               result_valid,
	input wvnn_pkg::result_t  result
);
	import wvnn_pkg::*;

	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result shown while not busy");

	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.kind == KIND_LOAD) |=> !busy)
		else $error("load request left the block busy");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last) |=>
			(result_valid && result.rank == RANK_BITS'($past(result.rank) + RANK_BITS'(1))))
		else $error("result burst broken or rank not consecutive");

	a_first_rank: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> (result.rank == '0))
		else $error("first result of a query not ranked zero");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last) |=> !busy)
		else $error("block still busy after final result");

endmodule

bind weight_vector_nearest_neighbours wvnn_checker u_wvnn_checker (.*);
